// ===== design/mvsm_pkg.sv =====
package mvsm_pkg;

	localparam int OP_W     = 3;
	localparam int ID_W     = 8;
	localparam int ADDR_W   = 16;
	localparam int LEN_W    = 17;
	localparam int BYTE_W   = 8;
	localparam int SAMPLE_W = 8;
	localparam int COUNT_W  = 5;
	localparam int RED_CNT_W = 4;

	localparam logic [BYTE_W-1:0] SIGN_FLIP = 8'h80;

	typedef enum logic [OP_W-1:0] {
		OP_TICK      = 3'd0,
		OP_PLAY      = 3'd1,
		OP_PLAY_LOOP = 3'd2,
		OP_STOP      = 3'd3,
		OP_STOP_ALL  = 3'd4,
		OP_WRITE     = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_WRITE,
		ST_PLAY,
		ST_WALK,
		ST_EMIT
	} state_t;

endpackage

// ===== design/mvsm_if.sv =====
interface mvsm_in_if import mvsm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [ID_W-1:0]     sound_id;
	logic [ADDR_W-1:0]   address;
	logic [LEN_W-1:0]    length;
	logic [BYTE_W-1:0]   wave_byte;

	modport source (output valid, op, sound_id, address, length, wave_byte, input ready);
	modport sink (input valid, op, sound_id, address, length, wave_byte, output ready);
endinterface

interface mvsm_out_if import mvsm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] mixed_sample;
	logic [COUNT_W-1:0]  voices_active;

	modport source (output valid, mixed_sample, voices_active, input ready);
	modport sink (input valid, mixed_sample, voices_active, output ready);
endinterface

// ===== design/multi_voice_sample_mixer.sv =====
// tick: for each voice, one voice record read, one wave memory read and, for an active voice,
// one add, through a shared two-stage walk; the clamped result is then registered in the emit state
// play (nonzero length): reduce steps, then a scan for a free voice; write: reduce steps, then the write
// stop: a walk over all voices; stop_all and unknown ops finish on accept; one command at a time
// reset: all voices off, output empty; wave memory is not cleared
module multi_voice_sample_mixer import mvsm_pkg::*; #(
	parameter int VOICES     = 16,
	parameter int WAVE_DEPTH = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	mvsm_in_if.sink      cmd,
	mvsm_out_if.source   mix
);

	localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AW        = $clog2(WAVE_DEPTH);
	localparam int SW        = $clog2(VOICES) + 9;
	localparam int CW        = $clog2(VOICES + 1);
	localparam int RED_STEPS = (WAVE_DEPTH >= 65536) ? 0
		: $clog2((65536 + WAVE_DEPTH - 1) / WAVE_DEPTH);
	localparam int RED_INIT  = (RED_STEPS > 0) ? (WAVE_DEPTH << (RED_STEPS - 1)) : 0;

	localparam logic [VW:0]        VCOUNT  = (VW+1)'(VOICES);
	localparam logic [VW:0]        VLAST   = (VW+1)'(VOICES - 1);
	localparam logic [AW:0]        DEPTH_W = (AW+1)'(WAVE_DEPTH);
	localparam logic signed [SW-1:0] SUM_HI = SW'(255);
	localparam logic signed [SW-1:0] SUM_LO = -SUM_HI;
	localparam logic [SW-1:0]      SUM_BIAS = SW'(256);

	typedef struct packed {
		logic              looping;
		logic [ID_W-1:0]   sound;
		logic [AW-1:0]     base;
		logic [AW-1:0]     ptr;
		logic [LEN_W-1:0]  offset;
		logic [LEN_W-1:0]  span;
	} voice_rec_t;

	state_t state_q, state_n;

	logic [OP_W-1:0]      op_q;
	logic [ID_W-1:0]      id_q;
	logic [LEN_W-1:0]     len_q;
	logic [BYTE_W-1:0]    byte_q;
	logic [LEN_W-1:0]     red_q;
	logic [LEN_W-1:0]     red_div_q;
	logic [RED_CNT_W-1:0] red_cnt_q;
	logic [VW:0]          vidx_q;
	logic [VOICES-1:0]    voice_on_q;

	logic                 vld_s1;
	logic [VW-1:0]        idx_s1;
	logic                 vld_s2;
	logic signed [SW-1:0] sum_q;
	logic [CW-1:0]        cnt_q;

	logic                 out_vld_q;
	logic [SAMPLE_W-1:0]  mixed_q;
	logic [COUNT_W-1:0]   active_q;

	voice_rec_t           rec_mem [VOICES];
	voice_rec_t           rec_rd_q;
	logic [BYTE_W-1:0]    wave_mem [WAVE_DEPTH];
	logic [BYTE_W-1:0]    wave_rd_q;

	logic                 accept;
	logic                 red_step;
	logic                 wave_we;
	logic                 play_hit;
	logic                 issue;
	logic                 emit_load;
	logic                 walk_done;
	logic                 is_tick;

	logic                 on_s1;
	logic [LEN_W-1:0]     off_inc;
	logic                 at_end;
	logic                 keep_s1;
	logic [AW:0]          ptr_inc;
	voice_rec_t           rec_next;
	logic                 clear_s1;
	logic                 rec_we;
	logic [VW-1:0]        rec_waddr;
	voice_rec_t           rec_wdata;
	logic [SW-1:0]        biased;

	assign is_tick   = (op_q == OP_TICK);
	assign walk_done = (vidx_q == VCOUNT) && !vld_s1 && !vld_s2;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					unique case (cmd.op)
						OP_TICK, OP_STOP: state_n = ST_WALK;
						OP_PLAY, OP_PLAY_LOOP: begin
							if (cmd.length != '0) state_n = ST_REDUCE;
						end
						OP_WRITE: state_n = ST_REDUCE;
						default: state_n = ST_IDLE;
					endcase
				end
			end
			ST_REDUCE: begin
				if (red_cnt_q == '0) state_n = (op_q == OP_WRITE) ? ST_WRITE : ST_PLAY;
			end
			ST_WRITE: state_n = ST_IDLE;
			ST_PLAY: begin
				if (!voice_on_q[vidx_q[VW-1:0]] || vidx_q == VLAST) state_n = ST_IDLE;
			end
			ST_WALK: begin
				if (walk_done) state_n = is_tick ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (!out_vld_q || mix.ready) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		accept    = 1'b0;
		red_step  = 1'b0;
		wave_we   = 1'b0;
		play_hit  = 1'b0;
		issue     = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   accept    = cmd.valid;
			ST_REDUCE: red_step  = (red_cnt_q != '0);
			ST_WRITE:  wave_we   = 1'b1;
			ST_PLAY:   play_hit  = !voice_on_q[vidx_q[VW-1:0]];
			ST_WALK:   issue     = (vidx_q < VCOUNT);
			ST_EMIT:   emit_load = !out_vld_q || mix.ready;
			default: ;
		endcase
	end

	assign cmd.ready = (state_q == ST_IDLE);

	// second walk stage: record update for tick, sound match for stop
	always_comb begin
		on_s1    = vld_s1 && voice_on_q[idx_s1];
		off_inc  = rec_rd_q.offset + LEN_W'(1);
		at_end   = (off_inc >= rec_rd_q.span);
		keep_s1  = !at_end || rec_rd_q.looping;
		ptr_inc  = {1'b0, rec_rd_q.ptr} + (AW+1)'(1);
		rec_next = rec_rd_q;
		if (at_end) begin
			rec_next.offset = '0;
			rec_next.ptr    = rec_rd_q.base;
		end else begin
			rec_next.offset = off_inc;
			rec_next.ptr    = (ptr_inc == DEPTH_W) ? '0 : ptr_inc[AW-1:0];
		end
		clear_s1 = on_s1 && (is_tick ? !keep_s1 : (rec_rd_q.sound == id_q));
	end

	always_comb begin
		rec_wdata.looping = (op_q == OP_PLAY_LOOP);
		rec_wdata.sound   = id_q;
		rec_wdata.base    = AW'(red_q);
		rec_wdata.ptr     = AW'(red_q);
		rec_wdata.offset  = '0;
		rec_wdata.span    = len_q;
		rec_waddr         = vidx_q[VW-1:0];
		rec_we            = play_hit;
		if (!play_hit) begin
			rec_wdata = rec_next;
			rec_waddr = idx_s1;
			rec_we    = on_s1 && is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
		rec_rd_q <= rec_mem[vidx_q[VW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wave_we) wave_mem[AW'(red_q)] <= byte_q ^ SIGN_FLIP;
		wave_rd_q <= wave_mem[rec_rd_q.ptr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			red_cnt_q  <= '0;
			vidx_q     <= '0;
			voice_on_q <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			vld_s1  <= issue;
			vld_s2  <= on_s1 && is_tick;

			if (accept) begin
				red_cnt_q <= RED_CNT_W'(RED_STEPS);
				vidx_q    <= '0;
			end else if (red_step) begin
				red_cnt_q <= red_cnt_q - RED_CNT_W'(1);
			end else if (issue || (state_q == ST_PLAY && !play_hit)) begin
				vidx_q <= vidx_q + (VW+1)'(1);
			end

			if (accept && cmd.op == OP_STOP_ALL) begin
				voice_on_q <= '0;
			end else if (play_hit) begin
				voice_on_q[vidx_q[VW-1:0]] <= 1'b1;
			end else if (clear_s1) begin
				voice_on_q[idx_s1] <= 1'b0;
			end

			if (emit_load) out_vld_q <= 1'b1;
			else if (mix.ready) out_vld_q <= 1'b0;
		end
	end

	assign biased = sum_q + SUM_BIAS;

	always_ff @(posedge clk) begin
		idx_s1 <= vidx_q[VW-1:0];
		if (accept) begin
			op_q      <= cmd.op;
			id_q      <= cmd.sound_id;
			len_q     <= cmd.length;
			byte_q    <= cmd.wave_byte;
			red_q     <= LEN_W'(cmd.address);
			red_div_q <= LEN_W'(RED_INIT);
			sum_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (red_step) begin
				if (red_q >= red_div_q) red_q <= red_q - red_div_q;
				red_div_q <= red_div_q >> 1;
			end
			if (vld_s2) sum_q <= sum_q + {{(SW-8){wave_rd_q[7]}}, wave_rd_q};
			if (on_s1 && is_tick && keep_s1) cnt_q <= cnt_q + CW'(1);
		end
		if (emit_load) begin
			priority if (sum_q < SUM_LO) mixed_q <= '0;
			else if (sum_q > SUM_HI) mixed_q <= '1;
			else mixed_q <= biased[8:1];
			active_q <= COUNT_W'(cnt_q);
		end
	end

	assign mix.valid         = out_vld_q;
	assign mix.mixed_sample  = mixed_q;
	assign mix.voices_active = active_q;

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside emit");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !vld_s1 && !vld_s2)
		else $error("walk pipeline busy in idle");

	a_s2_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(vld_s1))
		else $error("accumulate without record stage");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> cnt_q < CW'(VOICES) || cnt_q == CW'(VOICES))
		else $error("active count beyond voice count");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import mvsm_pkg::*;

	localparam int VOICE_COUNT = 16;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int QUIET_CYCLES = 4 * VOICE_COUNT;
	localparam int PRINT_CAP = 40;
	localparam int RANDOM_ITEMS = 500;
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   id;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] wbyte;
	} mixer_cmd_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [COUNT_W-1:0]  count;
	} mix_out_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   jitter;
	int   errors;
	int   cycle_count;
	int   ready_hold;

	mvsm_in_if  cmd();
	mvsm_out_if mix();

	multi_voice_sample_mixer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.mix    (mix)
	);

	// mixer state as the bench sees it
	bit                voice_on   [VOICE_COUNT];
	bit                voice_loop [VOICE_COUNT];
	logic [ID_W-1:0]   voice_id   [VOICE_COUNT];
	logic [ADDR_W-1:0] voice_base [VOICE_COUNT];
	logic [LEN_W-1:0]  voice_pos  [VOICE_COUNT];
	logic [LEN_W-1:0]  voice_len  [VOICE_COUNT];
	logic [BYTE_W-1:0] wave_mem   [0:65535];
	bit                wave_known [0:65535];
	mix_out_t          mix_expected[$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (!jitter)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		errors++;
		if (errors <= PRINT_CAP)
			$display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
	endtask

	function automatic mixer_cmd_t make_cmd(input logic [OP_W-1:0] op, input int id,
			input int addr, input int len, input int wbyte);
		mixer_cmd_t c;
		c.op = op;
		c.id = id[ID_W-1:0];
		c.addr = addr[ADDR_W-1:0];
		c.len = len[LEN_W-1:0];
		c.wbyte = wbyte[BYTE_W-1:0];
		return c;
	endfunction

	function automatic logic [ADDR_W-1:0] voice_addr(input int v);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(voice_base[v] + voice_pos[v]);
		return a;
	endfunction

	function automatic int rand_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return 0;
		if (r < 40)
			return 255;
		return $urandom_range(0, 255);
	endfunction

	function automatic int rand_id();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(0, 3);
		return $urandom_range(0, 255);
	endfunction

	function automatic int rand_base();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 'h2000 + $urandom_range(0, 255);
		if (r < 85)
			return 'hFFF0 + $urandom_range(0, 15);
		return $urandom_range(0, 65535);
	endfunction

	function automatic int rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 24);
		if (r < 90)
			return $urandom_range(25, 300);
		if (r < 97)
			return 0;
		return $urandom_range(65536, 131071);
	endfunction

	task automatic mix_tick_predict();
		int       sum;
		int       active;
		mix_out_t res;
		logic signed [BYTE_W-1:0] s;
		sum = 0;
		active = 0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			if (!voice_on[v])
				continue;
			s = wave_mem[voice_addr(v)];
			sum += int'(s);
			voice_pos[v] = voice_pos[v] + 1'b1;
			if (voice_pos[v] >= voice_len[v]) begin
				if (voice_loop[v])
					voice_pos[v] = '0;
				else
					voice_on[v] = 1'b0;
			end
			if (voice_on[v])
				active++;
		end
		if (sum < -255)
			res.sample = 8'd0;
		else if (sum > 255)
			res.sample = 8'd255;
		else
			res.sample = SAMPLE_W'((sum + 256) >> 1);
		res.count = active[COUNT_W-1:0];
		mix_expected.push_back(res);
	endtask

	task automatic apply_cmd(input mixer_cmd_t c);
		bit placed;
		placed = 1'b0;
		case (c.op)
			OP_TICK: begin
				mix_tick_predict();
			end
			OP_PLAY, OP_PLAY_LOOP: begin
				if (c.len != '0) begin
					for (int v = 0; v < VOICE_COUNT; v++) begin
						if (!placed && !voice_on[v]) begin
							placed = 1'b1;
							voice_on[v] = 1'b1;
							voice_loop[v] = (c.op == OP_PLAY_LOOP);
							voice_id[v] = c.id;
							voice_base[v] = c.addr;
							voice_pos[v] = '0;
							voice_len[v] = c.len;
						end
					end
				end
			end
			OP_STOP: begin
				for (int v = 0; v < VOICE_COUNT; v++)
					if (voice_on[v] && voice_id[v] == c.id)
						voice_on[v] = 1'b0;
			end
			OP_STOP_ALL: begin
				for (int v = 0; v < VOICE_COUNT; v++)
					voice_on[v] = 1'b0;
			end
			OP_WRITE: begin
				wave_mem[c.addr] = c.wbyte ^ SIGN_FLIP;
				wave_known[c.addr] = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic send_cmd(input mixer_cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.op <= c.op;
		cmd.sound_id <= c.id;
		cmd.address <= c.addr;
		cmd.length <= c.len;
		cmd.wave_byte <= c.wbyte;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		apply_cmd(c);
	endtask

	task automatic write_byte(input int addr, input int wbyte);
		send_cmd(make_cmd(OP_WRITE, $urandom_range(0, 255), addr, $urandom_range(0, 131071),
			wbyte));
	endtask

	task automatic start_sound(input bit loop, input int id, input int addr, input int len);
		send_cmd(make_cmd(loop ? OP_PLAY_LOOP : OP_PLAY, id, addr, len, $urandom_range(0, 255)));
	endtask

	task automatic stop_sound(input logic [OP_W-1:0] op, input int id);
		send_cmd(make_cmd(op, id, $urandom_range(0, 65535), $urandom_range(0, 131071),
			$urandom_range(0, 255)));
	endtask

	// every address a voice reads on this tick gets written first
	task automatic mix_tick();
		logic [ADDR_W-1:0] a;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			if (voice_on[v]) begin
				a = voice_addr(v);
				if (!wave_known[a])
					write_byte(int'(a), rand_byte());
			end
		end
		stop_sound(OP_TICK, $urandom_range(0, 255));
	endtask

	task automatic drain_results();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (mix_expected.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			mix.ready <= 1'b0;
			ready_hold--;
		end else begin
			mix.ready <= 1'b1;
			ready_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		mix_out_t want;
		if (arst_n === 1'b1 && mix.valid === 1'b1 && mix.ready === 1'b1) begin
			if (mix_expected.size() == 0) begin
				report_mismatch("mixed_sample with no tick pending", int'(mix.mixed_sample),
					-1);
			end else begin
				want = mix_expected.pop_front();
				if (mix.mixed_sample !== want.sample)
					report_mismatch("mixed_sample", int'(mix.mixed_sample),
						int'(want.sample));
				if (mix.voices_active !== want.count)
					report_mismatch("voices_active", int'(mix.voices_active),
						int'(want.count));
			end
		end
	end

	task automatic test_silence();
		start_sound(1'b0, 9, 'h0040, 0);
		mix_tick();
		mix_tick();
	endtask

	task automatic test_one_shot();
		write_byte('h0100, 'h00);
		write_byte('h0101, 'hFF);
		write_byte('h0102, 'h80);
		start_sound(1'b0, 1, 'h0100, 3);
		repeat (4) mix_tick();
	endtask

	task automatic test_loop_wrap();
		start_sound(1'b1, 2, 'hFFFF, 65536);
		start_sound(1'b1, 3, 'hFFFF, 2);
		repeat (4) mix_tick();
		stop_sound(OP_STOP, 2);
		mix_tick();
		drain_results();
	endtask

	task automatic test_voice_limit();
		for (int v = 0; v < VOICE_COUNT - 1; v++)
			start_sound(v[0], v, 'h3000, 2);
		start_sound(1'b1, 'hFF, 'hFFFF, 'h1FFFF);
		start_sound(1'b0, 7, 'h4000, 5);
		repeat (3) mix_tick();
		stop_sound(OP_STOP, 'hFF);
		stop_sound(OP_STOP, 200);
		mix_tick();
		stop_sound(OP_STOP_ALL, 0);
		mix_tick();
	endtask

	task automatic test_spare_ops();
		stop_sound(OP_SPARE_6, 'hFF);
		stop_sound(OP_SPARE_7, 0);
		mix_tick();
	endtask

	task automatic test_random_traffic();
		int issued;
		int r;
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			jitter = (issued % 120) < 80;
			if ($urandom_range(0, 49) == 0)
				drain_results();
			r = $urandom_range(0, 99);
			if (r < 40)
				mix_tick();
			else if (r < 55)
				start_sound(1'b0, rand_id(), rand_base(), rand_len());
			else if (r < 65)
				start_sound(1'b1, rand_id(), rand_base(), rand_len());
			else if (r < 73)
				stop_sound(OP_STOP, rand_id());
			else if (r < 76)
				stop_sound(OP_STOP_ALL, rand_id());
			else if (r < 96)
				write_byte(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
					: rand_base(), rand_byte());
			else
				stop_sound(r[0] ? OP_SPARE_6 : OP_SPARE_7, rand_id());
			if (r < 96)
				issued++;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.op <= OP_TICK;
		cmd.sound_id <= '0;
		cmd.address <= '0;
		cmd.length <= '0;
		cmd.wave_byte <= '0;
		jitter = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_silence();
		test_one_shot();
		test_loop_wrap();
		test_voice_limit();
		test_spare_ops();
		test_random_traffic();
		drain_results();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
